### rtl/core/assert_macros.svh
// assertion macros used by the checker file of the key allocator
// no dependencies; expects signals named clk and rst in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RKIA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define RKIA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// antecedent implies consequent a fixed number of cycles later
`define RKIA_ASSERT_DLY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

### rtl/core/rkia_pkg.sv
// shared types and constants of the refcounted key id allocator
// no dependencies
package rkia_pkg;

  // parameter defaults
  localparam int MAX_KEYS_DEF = 255;
  localparam int REF_BITS_DEF = 16;

  // operation codes
  localparam logic [2:0] KIND_CREATE  = 3'd0;
  localparam logic [2:0] KIND_DELETE  = 3'd1;
  localparam logic [2:0] KIND_ACQUIRE = 3'd2;
  localparam logic [2:0] KIND_RELEASE = 3'd3;
  localparam logic [2:0] KIND_CHECK   = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BADKEY   = 2'd1;
  localparam logic [1:0] STAT_NOSPACE  = 2'd2;
  localparam logic [1:0] STAT_OVERFLOW = 2'd3;

  // request word
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] key_id;
  } req_word_t;

  // result word
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] new_key;
  } rsp_word_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic look;
    logic pick;
    logic exec;
  } dp_cmd_t;

endpackage

### rtl/core/rkia_ctrl.sv
// sequencing state machine of the key allocator
// depends on rkia_pkg
module rkia_ctrl import rkia_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  output dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_PICK = 4'b0100,
    S_EXEC = 4'b1000
  } state_t;

  state_t state, state_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_LOOK;
      S_LOOK: state_next = S_PICK;
      S_PICK: state_next = S_EXEC;
      S_EXEC: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // commands and status
  assign busy     = (state != S_IDLE);
  assign cmd.load = (state == S_IDLE) && start;
  assign cmd.look = (state == S_LOOK);
  assign cmd.pick = (state == S_PICK);
  assign cmd.exec = (state == S_EXEC);

endmodule

### rtl/core/rkia_dp.sv
// datapath of the key allocator: flags, count memory, lowest free search
// depends on rkia_pkg
module rkia_dp import rkia_pkg::*; #(
  parameter int MAX_KEYS = MAX_KEYS_DEF,
  parameter int REF_BITS = REF_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  dp_cmd_t   cmd,
  input  req_word_t req,
  output logic      done,
  output rsp_word_t rsp
);

  // keys above 255 can only be issued by create and then stay active for good,
  // so only the low slots need storage
  localparam int SLOTS = (MAX_KEYS + 1 < 256) ? MAX_KEYS + 1 : 256;
  localparam int AW    = $clog2(SLOTS);
  localparam int NG    = (SLOTS + 31) / 32;
  localparam int FW    = NG * 32;
  localparam int HW_W  = $clog2(MAX_KEYS + 2);

  // request registers
  logic [2:0] kind_q;
  logic [7:0] key_q;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= req.kind;
      key_q  <= req.key_id;
    end
  end

  logic          in_range;
  logic [AW-1:0] addr;
  assign in_range = ({1'b0, key_q} < 9'(SLOTS));
  assign addr     = key_q[AW-1:0];

  // per key flags; held marks a nonzero count and doubles as the memory valid bit
  logic [SLOTS-1:0] active;
  logic [SLOTS-1:0] held;
  logic [HW_W-1:0]  hw;

  // count memory
  logic [REF_BITS-1:0] ref_mem [SLOTS];
  logic [REF_BITS-1:0] rd_q;
  logic                mem_we;
  logic [REF_BITS-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (cmd.look) rd_q <= ref_mem[addr];
    if (mem_we)   ref_mem[addr] <= wr_data;
  end

  // free vector: issued, not active, no references
  logic [FW-1:0] free;
  for (genvar k = 0; k < FW; k++) begin : g_free
    if (k > 0 && k < SLOTS) begin : g_slot
      assign free[k] = (HW_W'(k) < hw) && !active[k] && !held[k];
    end else begin : g_none
      assign free[k] = 1'b0;
    end
  end

  // stage one: lowest free bit in each group of 32
  logic [NG-1:0] grp_any;
  logic [4:0]    grp_idx [NG];
  for (genvar g = 0; g < NG; g++) begin : g_grp
    logic [31:0] v, low;
    logic [4:0]  idx;
    assign v   = free[g*32 +: 32];
    assign low = v & (~v + 32'd1);
    always_comb begin
      idx = '0;
      for (int i = 0; i < 32; i++) begin
        if (low[i]) idx = idx | 5'(i);
      end
    end
    always_ff @(posedge clk) begin
      if (cmd.look) begin
        grp_any[g] <= |v;
        grp_idx[g] <= idx;
      end
    end
  end

  // stage two: lowest group with a free key
  logic [NG-1:0] grp_low;
  logic [7:0]    pick_comb;
  logic          pick_found;
  logic [7:0]    pick_key;
  assign grp_low = grp_any & (~grp_any + NG'(1));
  always_comb begin
    pick_comb = '0;
    for (int g = 0; g < NG; g++) begin
      if (grp_low[g]) pick_comb = pick_comb | 8'(g * 32) | {3'b000, grp_idx[g]};
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      pick_found <= |grp_any;
      pick_key   <= pick_comb;
    end
  end

  // operation decode
  logic                live;
  logic [REF_BITS-1:0] cnt;
  logic                act_set, act_clr;
  logic [AW-1:0]       act_idx;
  logic                held_we, held_val;
  logic                hw_inc;
  logic [1:0]          stat;
  logic [7:0]          issued;

  assign live = (key_q != 8'd0) && in_range && active[addr];
  assign cnt  = held[addr] ? rd_q : '0;

  always_comb begin
    act_set  = 1'b0;
    act_clr  = 1'b0;
    act_idx  = addr;
    held_we  = 1'b0;
    held_val = 1'b0;
    mem_we   = 1'b0;
    wr_data  = cnt;
    hw_inc   = 1'b0;
    stat     = STAT_BADKEY;
    issued   = '0;
    case (kind_q)
      KIND_CREATE: begin
        if (pick_found) begin
          act_set = 1'b1;
          act_idx = pick_key[AW-1:0];
          issued  = pick_key;
          stat    = STAT_OK;
        end else if (hw > HW_W'(MAX_KEYS)) begin
          stat = STAT_NOSPACE;
        end else begin
          act_set = (hw < HW_W'(SLOTS));
          act_idx = hw[AW-1:0];
          hw_inc  = 1'b1;
          issued  = 8'(hw);
          stat    = STAT_OK;
        end
      end
      KIND_DELETE: begin
        if (live) begin
          act_clr = 1'b1;
          stat    = STAT_OK;
        end
      end
      KIND_ACQUIRE: begin
        if (live) begin
          if (&cnt) begin
            stat = STAT_OVERFLOW;
          end else begin
            mem_we   = cmd.exec;
            wr_data  = cnt + REF_BITS'(1);
            held_we  = 1'b1;
            held_val = 1'b1;
            stat     = STAT_OK;
          end
        end
      end
      KIND_RELEASE: begin
        if (in_range && held[addr]) begin
          mem_we   = cmd.exec;
          wr_data  = cnt - REF_BITS'(1);
          held_we  = 1'b1;
          held_val = (cnt != REF_BITS'(1));
        end
        stat = STAT_OK;
      end
      KIND_CHECK: begin
        if (live) stat = STAT_OK;
      end
      default: stat = STAT_BADKEY;
    endcase
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      held   <= '0;
      hw     <= HW_W'(1);
    end else if (cmd.exec) begin
      if (act_set) active[act_idx] <= 1'b1;
      if (act_clr) active[act_idx] <= 1'b0;
      if (held_we) held[addr] <= held_val;
      if (hw_inc)  hw <= hw + HW_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= cmd.exec;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp.status  <= stat;
      rsp.new_key <= issued;
    end
  end

endmodule

### rtl/core/refcounted_key_id_allocator_core.sv
// top level of the refcounted key id allocator
// depends on rkia_pkg, rkia_ctrl, rkia_dp
//
//   channel   handshake      word
//   request   start / busy   req  (kind, key_id)
//   result    done           rsp  (status, new_key)
//
// a request word is taken when start is high and busy is low; every operation
// then runs through the look state (first register stage of the lowest free key
// search, registered read of the reference count memory), the pick state (second
// stage) and the exec state (update), and its result word then shows with done.
// the next request may be taken in the same cycle the result is shown.
// synchronous reset clears all flags at once; no clearing pass is needed.
// done lasts one cycle and cannot be held off by the receiver.
module refcounted_key_id_allocator_core import rkia_pkg::*; #(
  parameter int MAX_KEYS = MAX_KEYS_DEF,
  parameter int REF_BITS = REF_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  req_word_t req,
  output logic      done,
  output rsp_word_t rsp
);

  dp_cmd_t cmd;

  // sequencer
  rkia_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // storage and operation logic
  rkia_dp #(
    .MAX_KEYS (MAX_KEYS),
    .REF_BITS (REF_BITS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

endmodule

### rtl/core/rkia_chk.sv
// port level checks of the key allocator, bound to the top level
// depends on rkia_pkg and assert_macros.svh
`include "assert_macros.svh"

module rkia_chk import rkia_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input logic      done,
  input rsp_word_t rsp
);

  `RKIA_ASSERT_NXT(a_busy_after_take, start && !busy, busy, "busy not raised after a taken word")
  `RKIA_ASSERT_DLY(a_latency, start && !busy, 4, done, "result word not shown 4 cycles after request")
  `RKIA_ASSERT_IMP(a_done_idle, done, !busy, "result shown while still busy")
  `RKIA_ASSERT_NXT(a_done_single, done, !done, "result strobe longer than one cycle")
  `RKIA_ASSERT_IMP(a_key_on_ok, done && rsp.status != STAT_OK, rsp.new_key == 8'd0, "key issued on failure")

endmodule

bind refcounted_key_id_allocator_core rkia_chk u_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

### verif/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for refcounted_key_id_allocator_core
// depends on rkia_pkg and the core rtl; a shadow model predicts every result word
module tb_top;
  import rkia_pkg::*;

  // unused operation codes the block must reject
  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0] KIND_SPARE_MID   = 3'd6;
  localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

  localparam int          KEY_SLOTS   = MAX_KEYS_DEF + 1;
  localparam logic [15:0] REFS_FULL   = '1;
  localparam int          RANDOM_OPS  = 1080;
  localparam int          ACQ_BURST   = 20;
  localparam int          DRAIN_CYCLES = 16;

  typedef struct {
    req_word_t   word;
    int unsigned gap;
  } queued_op_t;

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  req_word_t req   = '0;
  logic      busy;
  logic      done;
  rsp_word_t rsp;

  refcounted_key_id_allocator_core u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  always #10 clk = ~clk;

  // shadow copy of the key table
  logic        key_active [KEY_SLOTS];
  logic [15:0] key_refs   [KEY_SLOTS];
  logic [8:0]  fresh_key;

  queued_op_t  queued_reqs [$];
  rsp_word_t   key_op_results [$];
  int          fail_cnt   = 0;
  int unsigned burst_left = 0;

  initial begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      key_active[i] = 1'b0;
      key_refs[i]   = '0;
    end
    fresh_key = 9'd1;
  end

  function automatic bit key_live(input logic [7:0] key);
    return key != '0 && key_active[key];
  endfunction

  // apply one accepted word to the shadow table and queue its result
  task automatic apply_key_op(input req_word_t w);
    rsp_word_t r;
    int        lim;
    int        pick;
    int        k;
    r.status  = STAT_BADKEY;
    r.new_key = '0;
    case (w.kind)
      KIND_CREATE: begin
        lim  = (fresh_key < KEY_SLOTS) ? int'(fresh_key) : KEY_SLOTS;
        pick = 0;
        for (k = 1; k < lim; k++)
          if (pick == 0 && !key_active[k] && key_refs[k] == '0) pick = k;
        if (pick == 0 && fresh_key <= MAX_KEYS_DEF) begin
          pick      = int'(fresh_key);
          fresh_key = fresh_key + 9'd1;
        end
        if (pick != 0) begin
          key_active[pick] = 1'b1;
          r.new_key = 8'(pick);
          r.status  = STAT_OK;
        end else begin
          r.status = STAT_NOSPACE;
        end
      end
      KIND_DELETE: begin
        if (key_live(w.key_id)) begin
          key_active[w.key_id] = 1'b0;
          r.status = STAT_OK;
        end
      end
      KIND_ACQUIRE: begin
        if (key_live(w.key_id)) begin
          if (key_refs[w.key_id] == REFS_FULL) begin
            r.status = STAT_OVERFLOW;
          end else begin
            key_refs[w.key_id] = key_refs[w.key_id] + 16'd1;
            r.status = STAT_OK;
          end
        end
      end
      KIND_RELEASE: begin
        if (key_refs[w.key_id] != '0) key_refs[w.key_id] = key_refs[w.key_id] - 16'd1;
        r.status = STAT_OK;
      end
      KIND_CHECK: begin
        r.status = key_live(w.key_id) ? STAT_OK : STAT_BADKEY;
      end
      default: ;
    endcase
    key_op_results.push_back(r);
  endtask

  // idle cycles before a word, with occasional back-to-back bursts
  function automatic int unsigned draw_gap();
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(10, 30);
    return $urandom_range(0, 8);
  endfunction

  task automatic queue_op(input logic [2:0] kind, input logic [7:0] key,
                          input int unsigned gap);
    queued_op_t op;
    op.word.kind   = kind;
    op.word.key_id = key;
    op.gap         = gap;
    queued_reqs.push_back(op);
  endtask

  // driver: one request word per accepted start, each after its own gap
  bit          staged = 1'b0;
  req_word_t   staged_word;
  int unsigned staged_gap;
  queued_op_t  next_op;

  always @(posedge clk) begin
    if (rst) begin
      start  <= 1'b0;
      staged = 1'b0;
    end else begin
      if (start && !busy) apply_key_op(req);
      if (!start || !busy) begin
        if (!staged && queued_reqs.size() != 0) begin
          next_op     = queued_reqs.pop_front();
          staged      = 1'b1;
          staged_word = next_op.word;
          staged_gap  = next_op.gap;
        end
        if (staged && staged_gap == 0) begin
          req    <= staged_word;
          start  <= 1'b1;
          staged = 1'b0;
        end else begin
          start <= 1'b0;
          if (staged) staged_gap--;
        end
      end
    end
  end

  // monitor: compare each result word with the oldest prediction
  rsp_word_t want;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (key_op_results.size() == 0) begin
        $error("result word with no request pending: status %0d new_key %0d",
               rsp.status, rsp.new_key);
        fail_cnt++;
      end else begin
        want = key_op_results.pop_front();
        if (rsp.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, rsp.status);
          fail_cnt++;
        end
        if (rsp.new_key !== want.new_key) begin
          $error("new_key mismatch: expected %0d, got %0d", want.new_key, rsp.new_key);
          fail_cnt++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int          roll;
    logic [2:0]  kind;
    logic [7:0]  key;

    // key zero is never valid; release of it is harmless
    queue_op(KIND_CHECK,   8'd0, draw_gap());
    queue_op(KIND_DELETE,  8'd0, draw_gap());
    queue_op(KIND_ACQUIRE, 8'd0, draw_gap());
    queue_op(KIND_RELEASE, 8'd0, draw_gap());
    queue_op(KIND_CREATE,  8'hFF, draw_gap());
    queue_op(KIND_CREATE,  8'd0, draw_gap());
    // counting on a live key, then release past zero
    queue_op(KIND_ACQUIRE, 8'd1, draw_gap());
    queue_op(KIND_ACQUIRE, 8'd1, draw_gap());
    queue_op(KIND_CHECK,   8'd1, draw_gap());
    queue_op(KIND_RELEASE, 8'd1, draw_gap());
    queue_op(KIND_RELEASE, 8'd1, draw_gap());
    queue_op(KIND_RELEASE, 8'd1, draw_gap());
    // inactive key handling
    queue_op(KIND_DELETE,  8'd1, draw_gap());
    queue_op(KIND_CHECK,   8'd1, draw_gap());
    queue_op(KIND_ACQUIRE, 8'd1, draw_gap());
    queue_op(KIND_DELETE,  8'd1, draw_gap());
    queue_op(KIND_RELEASE, 8'hFF, draw_gap());
    queue_op(KIND_CHECK,   8'hFF, draw_gap());
    // reuse of the lowest free key; a referenced key is skipped
    queue_op(KIND_CREATE,  8'h55, draw_gap());
    queue_op(KIND_ACQUIRE, 8'd2, draw_gap());
    queue_op(KIND_DELETE,  8'd2, draw_gap());
    queue_op(KIND_CREATE,  8'hAA, draw_gap());
    queue_op(KIND_RELEASE, 8'd2, draw_gap());
    queue_op(KIND_CREATE,  8'd0, draw_gap());
    // unused kind codes
    queue_op(KIND_SPARE_FIRST, 8'hFF, draw_gap());
    queue_op(KIND_SPARE_MID,   8'h80, draw_gap());
    queue_op(KIND_SPARE_LAST,  8'h01, draw_gap());

    // use up the whole key space, last creates run out
    for (int i = 0; i < 260; i++) queue_op(KIND_CREATE, 8'($urandom()), draw_gap());
    queue_op(KIND_CHECK,   8'hFF, draw_gap());
    queue_op(KIND_ACQUIRE, 8'hFF, draw_gap());
    queue_op(KIND_RELEASE, 8'hFF, draw_gap());
    queue_op(KIND_DELETE,  8'hFF, draw_gap());
    queue_op(KIND_CREATE,  8'd0, draw_gap());
    queue_op(KIND_CREATE,  8'd0, draw_gap());

    // run one count up, back to back
    for (int i = 0; i < ACQ_BURST; i++) queue_op(KIND_ACQUIRE, 8'd7, 0);
    queue_op(KIND_ACQUIRE, 8'd7, draw_gap());
    queue_op(KIND_ACQUIRE, 8'd7, draw_gap());
    queue_op(KIND_RELEASE, 8'd7, draw_gap());
    queue_op(KIND_ACQUIRE, 8'd7, draw_gap());
    queue_op(KIND_ACQUIRE, 8'd7, draw_gap());

    // random mix over a full table, biased toward low keys
    for (int n = 0; n < RANDOM_OPS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 25)      kind = KIND_CREATE;
      else if (roll < 43) kind = KIND_DELETE;
      else if (roll < 63) kind = KIND_ACQUIRE;
      else if (roll < 83) kind = KIND_RELEASE;
      else if (roll < 95) kind = KIND_CHECK;
      else                kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
      key = ($urandom_range(0, 9) < 6) ? 8'($urandom()) : 8'($urandom_range(0, 15));
      queue_op(kind, key, draw_gap());
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (queued_reqs.size() != 0 || staged || start) @(negedge clk);
    while (key_op_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (key_op_results.size() != 0) begin
      $error("%0d result words never arrived", key_op_results.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("** refcounted_key_id_allocator_core: PASSED **");
    end else begin
      $display("** refcounted_key_id_allocator_core: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("** refcounted_key_id_allocator_core: FAILED **");
    $finish;
  end

endmodule
